@@ hdl/lcnc_pkg.sv @@
package lcnc_pkg;

    localparam int CARD_W  = 63;
    localparam int DIGITS  = 19;
    localparam int BCD_W   = DIGITS * 4;
    localparam int CNT_W   = 6;
    localparam int COUNT_W = 5;

    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(CARD_W - 1);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(DIGITS - 1);

    localparam logic [COUNT_W-1:0] LEN_MIN   = COUNT_W'(13);
    localparam logic [COUNT_W-1:0] LEN_AMEX  = COUNT_W'(15);
    localparam logic [COUNT_W-1:0] LEN_MAX   = COUNT_W'(16);

    localparam logic [3:0] DEC_NINE = 4'd9;
    localparam logic [4:0] DEC_TEN  = 5'd10;

    typedef enum logic [1:0] {
        VERDICT_INVALID = 2'd0,
        VERDICT_AMEX    = 2'd1,
        VERDICT_MASTER  = 2'd2,
        VERDICT_VISA    = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

@@ hdl/lcnc_dabble.sv @@
// One shift-add-3 step of binary to packed-decimal conversion.
module lcnc_dabble
    import lcnc_pkg::*;
(
    input  logic [BCD_W-1:0] i_bcd,
    input  logic             i_bit,
    output logic [BCD_W-1:0] o_bcd
);

    logic [BCD_W-1:0] s_adj;

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (i_bcd[i*4 +: 4] >= 4'd5) begin
                s_adj[i*4 +: 4] = i_bcd[i*4 +: 4] + 4'd3;
            end else begin
                s_adj[i*4 +: 4] = i_bcd[i*4 +: 4];
            end
        end
    end

    assign o_bcd = {s_adj[BCD_W-2:0], i_bit};

endmodule

@@ hdl/lcnc_luhn_acc.sv @@
// Adds one digit to the running Luhn sum, kept modulo ten.
module lcnc_luhn_acc
    import lcnc_pkg::*;
(
    input  logic [3:0] i_digit,
    input  logic       i_odd,
    input  logic [3:0] i_sum,
    output logic [3:0] o_sum
);

    logic [4:0] s_dbl;
    logic [4:0] s_val;
    logic [4:0] s_tot;

    always_comb begin
        s_dbl = {i_digit, 1'b0};
        if (i_odd) begin
            s_val = (s_dbl > {1'b0, DEC_NINE}) ? s_dbl - {1'b0, DEC_NINE} : s_dbl;
        end else begin
            s_val = {1'b0, i_digit};
        end
        s_tot = s_val + {1'b0, i_sum};
        if (s_tot >= DEC_TEN) begin
            o_sum = 4'(s_tot - DEC_TEN);
        end else begin
            o_sum = s_tot[3:0];
        end
    end

endmodule

@@ hdl/luhn_card_number_classifier.sv @@
// Card number classifier: checks the Luhn mod-10 sum, counts decimal digits
// and picks the brand from the two leading digits. Each number passes through
// an accept cycle, bit-serial binary to decimal conversion (one shift-add-3
// step per input bit), a scan of the decimal digits one per cycle through the
// Luhn adder, and a classify cycle. o_in_stall stays high from accept until
// the result moves into the output register. A finished result sits in the
// output register until taken, and the next number may be accepted while it
// waits; if it is still waiting when the next classify cycle comes, that
// cycle holds and the input stays stalled.
module luhn_card_number_classifier
    import lcnc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CARD_W-1:0]   i_card_number,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_verdict,
    output logic                o_checksum_ok,
    output logic [COUNT_W-1:0]  o_digit_count
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CARD_W-1:0]  r_bin, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [3:0]         r_sum, n_sum;
    logic [3:0]         r_prev, n_prev;
    logic [3:0]         r_hi, n_hi;
    logic [3:0]         r_lo, n_lo;
    logic [COUNT_W-1:0] r_last, n_last;
    logic               r_any, n_any;

    logic               r_out_valid;
    t_verdict           r_verdict, n_verdict;
    logic               r_ok, n_ok;
    logic [COUNT_W-1:0] r_count, n_count;

    logic               s_accept;
    logic               s_load;
    logic [BCD_W-1:0]   s_bcd_step;
    logic [3:0]         s_digit;
    logic [3:0]         s_sum_step;

    lcnc_dabble u_dabble (
        .i_bcd (r_bcd),
        .i_bit (r_bin[CARD_W-1]),
        .o_bcd (s_bcd_step)
    );

    assign s_digit = r_bcd[3:0];

    lcnc_luhn_acc u_acc (
        .i_digit (s_digit),
        .i_odd   (r_cnt[0]),
        .i_sum   (r_sum),
        .o_sum   (s_sum_step)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (r_cnt == CONV_LAST) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_cnt == SCAN_LAST) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        s_accept   = 1'b0;
        s_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                s_accept   = i_in_valid;
            end
            ST_CONV: ;
            ST_SCAN: ;
            ST_DONE: begin
                s_load = !r_out_valid || !i_out_stall;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        n_cnt  = r_cnt;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_sum  = r_sum;
        n_prev = r_prev;
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_last = r_last;
        n_any  = r_any;
        if (s_accept) begin
            n_cnt = '0;
            n_bin = i_card_number;
            n_bcd = '0;
        end else if (r_state == ST_CONV) begin
            n_bcd = s_bcd_step;
            n_bin = {r_bin[CARD_W-2:0], 1'b0};
            if (r_cnt == CONV_LAST) begin
                n_cnt  = '0;
                n_sum  = '0;
                n_prev = '0;
                n_any  = 1'b0;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end else if (r_state == ST_SCAN) begin
            n_sum  = s_sum_step;
            n_prev = s_digit;
            n_bcd  = {4'd0, r_bcd[BCD_W-1:4]};
            n_cnt  = r_cnt + CNT_W'(1);
            // highest nonzero digit so far and the one to its right
            if (s_digit != 4'd0) begin
                n_any  = 1'b1;
                n_last = r_cnt[COUNT_W-1:0];
                n_hi   = s_digit;
                n_lo   = r_prev;
            end
        end
    end

    // classify
    always_comb begin
        n_count   = r_any ? COUNT_W'(r_last + COUNT_W'(1)) : COUNT_W'(1);
        n_ok      = (n_count >= LEN_MIN) && (n_count <= LEN_MAX) && (r_sum == 4'd0);
        n_verdict = VERDICT_INVALID;
        if (n_ok) begin
            if (r_hi == 4'd3 && (r_lo == 4'd4 || r_lo == 4'd7) && n_count == LEN_AMEX) begin
                n_verdict = VERDICT_AMEX;
            end else if (r_hi == 4'd5 && r_lo >= 4'd1 && r_lo <= 4'd5
                         && n_count == LEN_MAX) begin
                n_verdict = VERDICT_MASTER;
            end else if (r_hi == 4'd4 && (n_count == LEN_MIN || n_count == LEN_MAX)) begin
                n_verdict = VERDICT_VISA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_sum  <= n_sum;
        r_prev <= n_prev;
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_last <= n_last;
        r_any  <= n_any;
        if (s_load) begin
            r_verdict <= n_verdict;
            r_ok      <= n_ok;
            r_count   <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_verdict     = r_verdict;
    assign o_checksum_ok = r_ok;
    assign o_digit_count = r_count;

endmodule
